[src/bffa_pkg.sv]
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types, constants and helpers of the bitmap first-free allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int BIT_IDX_W   = 15;
    localparam int BYTE_IDX_W  = 12;
    localparam int BIT_POS_W   = 3;
    localparam int INDEX_BYTES = 32'h1000;
    localparam logic [7:0] FULL_BYTE = 8'hff;

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FIND  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [BIT_IDX_W-1:0] free_index;
        logic                 found;
        logic                 bit_value;
    } t_result;

    // position of the lowest zero bit, 0 for a full byte
    function automatic logic [BIT_POS_W-1:0] lowest_zero(input logic [7:0] v);
        logic [BIT_POS_W-1:0] pos;
        pos = '0;
        for (int p = 7; p >= 0; p--) begin
            if (!v[p]) begin
                pos = BIT_POS_W'(p);
            end
        end
        return pos;
    endfunction

endpackage

[src/bffa_ram.sv]
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/bffa_core.sv]
// ----------------------------------------------------------------------------
// bffa_core
// Sequencer: wipe pass after reset, byte read-modify-write, first-free scan.
// ----------------------------------------------------------------------------
module bffa_core #(
    parameter int MAP_BYTES = 4096,
    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  bffa_pkg::t_opcode                 i_opcode,
    input  logic [bffa_pkg::BIT_IDX_W-1:0]    i_bit_index,
    output logic                              o_mem_we,
    output logic [AW-1:0]                     o_mem_waddr,
    output logic [7:0]                        o_mem_wdata,
    output logic                              o_mem_re,
    output logic [AW-1:0]                     o_mem_raddr,
    input  logic [7:0]                        i_mem_rdata,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output bffa_pkg::t_result                 o_res
);

    localparam int SCAN_BYTES = (MAP_BYTES < bffa_pkg::INDEX_BYTES) ?
                                MAP_BYTES : bffa_pkg::INDEX_BYTES;
    localparam logic [bffa_pkg::BYTE_IDX_W-1:0] SCAN_LAST =
        bffa_pkg::BYTE_IDX_W'(SCAN_BYTES - 1);
    localparam logic [AW-1:0] WIPE_LAST = AW'(MAP_BYTES - 1);

    bffa_pkg::t_state                       r_state, n_state;
    bffa_pkg::t_opcode                      r_op, n_op;
    logic [bffa_pkg::BIT_POS_W-1:0]         r_bit, n_bit;
    logic [bffa_pkg::BYTE_IDX_W-1:0]        r_byte, n_byte;
    logic [bffa_pkg::BYTE_IDX_W-1:0]        r_scan, n_scan;
    logic [AW-1:0]                          r_wipe, n_wipe;
    bffa_pkg::t_result                      r_res, n_res;

    logic [bffa_pkg::BYTE_IDX_W-1:0]        in_byte;
    logic                                   in_range;
    logic [7:0]                             mask;
    logic                                   done;
    bffa_pkg::t_result                      res;

    assign in_byte  = i_bit_index[bffa_pkg::BIT_IDX_W-1:bffa_pkg::BIT_POS_W];
    assign in_range = ({20'd0, in_byte} < 32'(MAP_BYTES));
    assign mask     = 8'h01 << r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bffa_pkg::ST_WIPE;
            r_wipe  <= '0;
        end else begin
            r_state <= n_state;
            r_wipe  <= n_wipe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_bit  <= n_bit;
        r_byte <= n_byte;
        r_scan <= n_scan;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_scan      = r_scan;
        n_wipe      = r_wipe;
        n_res       = r_res;
        o_ready     = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(r_byte);
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = AW'(in_byte);
        done        = 1'b0;
        res         = '0;

        unique case (r_state)
            bffa_pkg::ST_WIPE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_wipe;
                if (r_wipe == WIPE_LAST) begin
                    n_state = bffa_pkg::ST_IDLE;
                end else begin
                    n_wipe = r_wipe + 1'b1;
                end
            end
            bffa_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op   = i_opcode;
                    n_bit  = i_bit_index[bffa_pkg::BIT_POS_W-1:0];
                    n_byte = in_byte;
                    if (i_opcode == bffa_pkg::OP_FIND) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = '0;
                        n_scan      = '0;
                        n_state     = bffa_pkg::ST_SCAN;
                    end else if (in_range) begin
                        o_mem_re = 1'b1;
                        n_state  = bffa_pkg::ST_RMW;
                    end else begin
                        n_res   = '0;
                        n_state = bffa_pkg::ST_RESULT;
                    end
                end
            end
            bffa_pkg::ST_RMW: begin
                done = 1'b1;
                unique case (r_op)
                    bffa_pkg::OP_QUERY: begin
                        res.bit_value = |(i_mem_rdata & mask);
                    end
                    bffa_pkg::OP_SET: begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = i_mem_rdata | mask;
                    end
                    bffa_pkg::OP_CLEAR: begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = i_mem_rdata & ~mask;
                    end
                    bffa_pkg::OP_FIND: begin
                        res = '0;
                    end
                endcase
            end
            bffa_pkg::ST_SCAN: begin
                if (i_mem_rdata != bffa_pkg::FULL_BYTE) begin
                    done           = 1'b1;
                    res.found      = 1'b1;
                    res.free_index = {r_scan, bffa_pkg::lowest_zero(i_mem_rdata)};
                end else if (r_scan == SCAN_LAST) begin
                    done = 1'b1;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(r_scan + 1'b1);
                    n_scan      = r_scan + 1'b1;
                end
            end
            bffa_pkg::ST_RESULT: begin
                done = 1'b1;
                res  = r_res;
            end
            default: begin
                n_state = bffa_pkg::ST_IDLE;
            end
        endcase

        o_res_valid = done;
        o_res       = res;
        if (done) begin
            if (i_res_ready) begin
                n_state = bffa_pkg::ST_IDLE;
            end else begin
                n_res   = res;
                n_state = bffa_pkg::ST_RESULT;
            end
        end
    end

endmodule

[src/bitmap_first_free_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// Used/free bitmap in a byte RAM with query, set, clear and find-first-free.
// ----------------------------------------------------------------------------
//  channel   dir  payload (lsb first)                       handshake
//  s         in   opcode[1:0], bit_index[16:2]             i_s_tvalid / o_s_tready
//  m         out  bit_value[0], found[1], free_index[16:2] o_m_tvalid / i_m_tready
//
//  query, set, clear: one RAM read, then a write-back for set and clear
//  find: the scan stops at the first byte that is not full, else after the last scanned byte
//  the scan reads one RAM byte per cycle from byte 0
//  after reset a wipe pass zeroes every RAM byte, o_s_tready low
//  one transaction in flight; a result register lets the next input enter
//  while the previous result waits on i_m_tready
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator #(
    parameter int MAP_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // opcode[1:0], bit_index[16:2], zero[23:17]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // bit_value[0], found[1], free_index[16:2], zero[23:17]
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [7:0]        mem_rdata;
    logic              res_valid;
    logic              out_free;
    bffa_pkg::t_result res;

    logic              r_out_valid;
    bffa_pkg::t_result r_out;

    assign out_free = !r_out_valid || i_m_tready;

    bffa_core #(
        .MAP_BYTES (MAP_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_opcode    (bffa_pkg::t_opcode'(i_s_tdata[1:0])),
        .i_bit_index (i_s_tdata[16:2]),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (out_free),
        .o_res       (res)
    );

    bffa_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.free_index, r_out.found, r_out.bit_value};

    a_reset_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready right after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transaction accepted while one is in flight");

    a_query_find_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("result marks both a set bit and a found index");

    a_index_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[1] |-> o_m_tdata[16:2] == '0)
        else $error("free index reported without found");

    a_result_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && r_out_valid && !i_m_tready |=> $stable(r_out))
        else $error("pending result overwritten");

endmodule

[tb/bffa_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bffa_checker
// Watches both stream channels of the bitmap allocator, keeps its own copy of
// the used/free map, predicts one result per accepted input transaction and
// compares every output transaction field by field against the oldest one.
// ----------------------------------------------------------------------------
module bffa_checker #(
    parameter int MAP_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // opcode[1:0], bit_index[16:2], zero[23:17]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // bit_value[0], found[1], free_index[16:2], zero[23:17]
    output int          o_fail_count,
    output int          o_pending
);

    import bffa_pkg::*;

    localparam int SCAN_LIMIT = (MAP_BYTES < INDEX_BYTES) ? MAP_BYTES : INDEX_BYTES;

    logic [7:0] alloc_map [MAP_BYTES];
    t_result    expected_results [$];
    int         mismatch_count = 0;

    function automatic t_result apply_bitmap_op(input t_opcode op,
                                                input logic [BIT_IDX_W-1:0] idx);
        t_result    res;
        int         byte_addr;
        logic [7:0] mask;
        int         first_open;
        int         pos;
        bit         hit;
        res        = '0;
        byte_addr  = int'(idx[BIT_IDX_W-1:BIT_POS_W]);
        mask       = 8'(1) << idx[BIT_POS_W-1:0];
        first_open = -1;
        pos        = 0;
        hit        = 1'b0;
        case (op)
            OP_QUERY: begin
                if (byte_addr < MAP_BYTES) begin
                    res.bit_value = |(alloc_map[byte_addr] & mask);
                end
            end
            OP_SET: begin
                if (byte_addr < MAP_BYTES) begin
                    alloc_map[byte_addr] = alloc_map[byte_addr] | mask;
                end
            end
            OP_CLEAR: begin
                if (byte_addr < MAP_BYTES) begin
                    alloc_map[byte_addr] = alloc_map[byte_addr] & ~mask;
                end
            end
            default: begin
                for (int b = 0; b < SCAN_LIMIT && first_open < 0; b++) begin
                    if (alloc_map[b] != FULL_BYTE) begin
                        first_open = b;
                    end
                end
                if (first_open >= 0) begin
                    for (int p = 0; p < 8; p++) begin
                        if (!hit && !alloc_map[first_open][p]) begin
                            pos = p;
                            hit = 1'b1;
                        end
                    end
                    res.found      = 1'b1;
                    res.free_index = BIT_IDX_W'(first_open * 8 + pos);
                end
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            foreach (alloc_map[i]) begin
                alloc_map[i] = 8'h00;
            end
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[BIT_IDX_W+1:0]);
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: tdata 0x%06h", i_m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("bit_value", int'(want.bit_value), int'(got.bit_value));
                    check_field("found", int'(want.found), int'(got.found));
                    check_field("free_index", int'(want.free_index), int'(got.free_index));
                    check_field("tdata padding", 0, int'(i_m_tdata[23:BIT_IDX_W+2]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(apply_bitmap_op(t_opcode'(i_s_tdata[1:0]),
                                                           i_s_tdata[BIT_IDX_W+1:2]));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bitmap first-free allocator: directed corner
// transactions, randomized allocate/free traffic under changing back-pressure,
// then a dense fill of the low bytes while probing the scan.
// ----------------------------------------------------------------------------
module tb_top;

    import bffa_pkg::*;

    localparam int MAP_BYTES = 4096;
    localparam int MAP_BITS  = 1 << BIT_IDX_W;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [23:0] s_tdata    = '0;
    logic        m_tready   = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    int fail_count;
    int pending;
    int tx_idle_pct = 25;
    int rx_idle_pct = 63;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    always #5 i_clk = ~i_clk;

    bitmap_first_free_allocator #(
        .MAP_BYTES (MAP_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    bffa_checker #(
        .MAP_BYTES (MAP_BYTES)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input t_opcode op, input logic [BIT_IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, idx, op};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
    endtask

    // allocation runs from a base, frees, and loose single transactions
    task automatic random_traffic(input int count);
        int n;
        int r;
        int base;
        int len;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                base = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 511);
                len  = $urandom_range(1, 48);
                for (int k = 0; k < len; k++) begin
                    send_item(OP_SET, BIT_IDX_W'(base + k));
                end
                send_item(OP_FIND, BIT_IDX_W'($urandom));
                n += len + 1;
            end else if (r < 40) begin
                send_item(OP_CLEAR, BIT_IDX_W'($urandom_range(0, 639)));
                send_item(OP_FIND, BIT_IDX_W'($urandom));
                n += 2;
            end else begin
                send_item(t_opcode'($urandom_range(0, 3)),
                          $urandom_range(0, 1) ? BIT_IDX_W'($urandom_range(0, 1023))
                                               : BIT_IDX_W'($urandom_range(0, MAP_BITS - 1)));
                n += 1;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners on a freshly wiped map
        send_item(OP_FIND, '0);
        send_item(OP_QUERY, '0);
        send_item(OP_QUERY, '1);
        send_item(OP_SET, '0);
        send_item(OP_QUERY, '0);
        send_item(OP_FIND, '1);
        for (int i = 1; i < 8; i++) begin
            send_item(OP_SET, BIT_IDX_W'(i));
        end
        send_item(OP_FIND, '0);
        send_item(OP_SET, '1);
        send_item(OP_QUERY, '1);
        send_item(OP_CLEAR, '1);
        send_item(OP_QUERY, '1);
        send_item(OP_CLEAR, BIT_IDX_W'(3));
        send_item(OP_FIND, '0);
        send_item(OP_QUERY, BIT_IDX_W'(3));
        send_item(OP_SET, BIT_IDX_W'(3));

        // stall the result side long enough to back up the input
        hold_req <= hold_req + 1;
        random_traffic(250);

        tx_idle_pct = 63;
        rx_idle_pct = 25;
        random_traffic(250);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(240);

        // pack the low bytes solid, probing the scan as it grows
        for (int i = 0; i < 64; i++) begin
            send_item(OP_SET, BIT_IDX_W'(i));
            if (i % 16 == 15) begin
                send_item(OP_FIND, BIT_IDX_W'($urandom));
            end
        end
        send_item(OP_FIND, '0);
        send_item(OP_QUERY, '0);
        send_item(OP_CLEAR, '1);
        send_item(OP_FIND, '0);
        send_item(OP_QUERY, '1);
        send_item(OP_CLEAR, '0);
        send_item(OP_FIND, '1);
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[bitmap_first_free_allocator.f]
src/bffa_pkg.sv
src/bffa_ram.sv
src/bffa_core.sv
src/bitmap_first_free_allocator.sv
tb/bffa_checker.sv
tb/tb_top.sv
